>>> rtl/qeel_pkg.sv
// Shared widths, codes and record types for the quad edge expand and line fit unit.
package qeel_pkg;

   localparam int COORD_W   = 16;
   localparam int RATIO_W   = 16;
   localparam int IDX_W     = 6;
   localparam int EDGE_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int FRAC_W    = 16;
   localparam int PT_W      = COORD_W + 2;
   localparam int DIFF_W    = PT_W + 1;
   localparam int MUL_W     = COORD_W + RATIO_W + 2;
   localparam int EXP_ACC_W = MUL_W + 2;
   localparam int NUM_W     = PT_W + FRAC_W;
   localparam int DIV_STAGES = NUM_W;
   localparam int SLOPE_W   = 32;
   localparam int ICPT_W    = 48;
   localparam int ICPT_SH   = 4;
   localparam int PROD_W    = SLOPE_W + PT_W;
   localparam int ACC_W     = PROD_W + 1;
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 192;

   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_RATIO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_RATIO  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INDEX  = 2'd2;

   localparam logic [RATIO_W-1:0] NEAR_RATIO_RST = 16'd18204;
   localparam logic [RATIO_W-1:0] FAR_RATIO_RST  = 16'd9930;
   localparam logic [IDX_W-1:0]   MAX_INDEX_RST  = 6'd54;

   localparam logic [EDGE_W-1:0] EDGE_FIRST = 2'd0;
   localparam logic [EDGE_W-1:0] EDGE_LAST  = 2'd3;

   localparam logic signed [SLOPE_W-1:0] SLOPE_VERT = 32'sd65536000;
   localparam logic signed [SLOPE_W-1:0] SLOPE_MAX  = {1'b0, {(SLOPE_W-1){1'b1}}};
   localparam logic signed [SLOPE_W-1:0] SLOPE_MIN  = {1'b1, {(SLOPE_W-1){1'b0}}};
   localparam logic [NUM_W-1:0] QUO_POS_LIM =
      {{(NUM_W-SLOPE_W+1){1'b0}}, {(SLOPE_W-1){1'b1}}};
   localparam logic [NUM_W-1:0] QUO_NEG_LIM = QUO_POS_LIM + 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0]          idx;
      logic [EDGE_W-1:0]         edge_no;
      logic                      last;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
   } side_type;

   typedef struct packed {
      side_type               side;
      logic signed [PT_W-1:0] sx;
      logic signed [PT_W-1:0] sy;
      logic signed [PT_W-1:0] mx;
      logic signed [PT_W-1:0] my;
      logic                   vert;
      logic                   neg;
   } line_side_type;

   typedef struct packed {
      side_type                  side;
      logic signed [PT_W-1:0]    sx;
      logic signed [PT_W-1:0]    sy;
      logic signed [PT_W-1:0]    mx;
      logic signed [PT_W-1:0]    my;
      logic signed [SLOPE_W-1:0] slope;
      logic signed [ICPT_W-1:0]  icpt;
   } rsp_type;

endpackage

>>> rtl/qeel_expand.sv
// Three-stage corner push-out for one coordinate: differences, products, round and clamp.
module qeel_expand import qeel_pkg::*; (
   input  logic                      clock,
   input  logic                      adv,
   input  logic signed [COORD_W-1:0] p,
   input  logic signed [COORD_W-1:0] qn,
   input  logic signed [COORD_W-1:0] qf,
   input  logic [RATIO_W-1:0]        near_ratio,
   input  logic [RATIO_W-1:0]        far_ratio,
   output logic signed [PT_W-1:0]    e
);

   localparam logic signed [EXP_ACC_W-1:0] EXP_HI =
      {{(EXP_ACC_W-PT_W+1){1'b0}}, {(PT_W-1){1'b1}}};
   localparam logic signed [EXP_ACC_W-1:0] EXP_LO = ~EXP_HI;
   localparam logic signed [EXP_ACC_W-1:0] EXP_RND =
      {{(EXP_ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

   logic signed [COORD_W-1:0]   p1_ff, p2_ff;
   logic signed [COORD_W:0]     dn_in, df_in, dn1_ff, df1_ff;
   logic signed [MUL_W-1:0]     pn_in, pf_in, pn2_ff, pf2_ff;
   logic signed [EXP_ACC_W-1:0] acc_in, sh_in;
   logic signed [PT_W-1:0]      e_in, e_ff;

   assign dn_in = {p[COORD_W-1], p} - {qn[COORD_W-1], qn};
   assign df_in = {p[COORD_W-1], p} - {qf[COORD_W-1], qf};
   assign pn_in = $signed({1'b0, near_ratio}) * dn1_ff;
   assign pf_in = $signed({1'b0, far_ratio}) * df1_ff;

   always_comb begin
      acc_in = (EXP_ACC_W'(p2_ff) <<< FRAC_W) + EXP_ACC_W'(pn2_ff) + EXP_ACC_W'(pf2_ff)
             + EXP_RND;
      sh_in  = acc_in >>> FRAC_W;
      if (sh_in > EXP_HI) begin
         e_in = EXP_HI[PT_W-1:0];
      end else if (sh_in < EXP_LO) begin
         e_in = EXP_LO[PT_W-1:0];
      end else begin
         e_in = sh_in[PT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff  <= p;
         dn1_ff <= dn_in;
         df1_ff <= df_in;
         p2_ff  <= p1_ff;
         pn2_ff <= pn_in;
         pf2_ff <= pf_in;
         e_ff   <= e_in;
      end
   end

   assign e = e_ff;

endmodule

>>> rtl/qeel_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module qeel_div import qeel_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [PT_W-1:0]    in_den,
   input  line_side_type      in_side,
   output logic               out_valid,
   output logic [NUM_W-1:0]   out_quo,
   output line_side_type      out_side
);

   logic                v_ff    [DIV_STAGES];
   logic [PT_W-1:0]     rem_ff  [DIV_STAGES];
   logic [NUM_W-1:0]    num_ff  [DIV_STAGES];
   logic [NUM_W-1:0]    quo_ff  [DIV_STAGES];
   logic [PT_W-1:0]     den_ff  [DIV_STAGES];
   line_side_type       side_ff [DIV_STAGES];

   genvar s;
   generate
      for (s = 0; s < DIV_STAGES; s++) begin : g_stage
         logic            v_src;
         logic [PT_W-1:0] rem_src, den_src;
         logic [NUM_W-1:0] num_src, quo_src;
         line_side_type   side_src;
         logic [PT_W:0]   trial;
         logic            ge;

         if (s == 0) begin : g_head
            assign v_src    = in_valid;
            assign rem_src  = '0;
            assign num_src  = in_num;
            assign quo_src  = '0;
            assign den_src  = in_den;
            assign side_src = in_side;
         end else begin : g_body
            assign v_src    = v_ff[s-1];
            assign rem_src  = rem_ff[s-1];
            assign num_src  = num_ff[s-1];
            assign quo_src  = quo_ff[s-1];
            assign den_src  = den_ff[s-1];
            assign side_src = side_ff[s-1];
         end

         assign trial = {rem_src, num_src[NUM_W-1]};
         assign ge    = trial >= {1'b0, den_src};

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[s] <= 1'b0;
            end else if (adv) begin
               v_ff[s] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s]  <= ge ? PT_W'(trial - {1'b0, den_src}) : trial[PT_W-1:0];
               num_ff[s]  <= {num_src[NUM_W-2:0], 1'b0};
               quo_ff[s]  <= {quo_src[NUM_W-2:0], ge};
               den_ff[s]  <= den_src;
               side_ff[s] <= side_src;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_quo   = quo_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

>>> rtl/qeel_line.sv
// Edge line fit: deltas and midpoint, slope division, clamp, intercept product and output beat.
module qeel_line import qeel_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  side_type               in_side,
   input  logic signed [PT_W-1:0] sx,
   input  logic signed [PT_W-1:0] sy,
   input  logic signed [PT_W-1:0] ex,
   input  logic signed [PT_W-1:0] ey,
   output logic                   out_valid,
   output rsp_type                out_rsp
);

   localparam logic signed [ACC_W-1:0] ICPT_HI =
      {{(ACC_W-ICPT_W+1){1'b0}}, {(ICPT_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ICPT_LO = ~ICPT_HI;
   localparam logic signed [ACC_W-1:0] ICPT_RND =
      {{(ACC_W-ICPT_SH){1'b0}}, 1'b1, {(ICPT_SH-1){1'b0}}};

   logic signed [DIFF_W-1:0] dx, dy, msum_x, msum_y, adx, ady;
   line_side_type            l1_side_in, l1_side_ff, dq_side;
   logic                     l1_v_ff, dq_v, k_v_ff, pr_v_ff, out_v_ff;
   logic [NUM_W-1:0]         l1_num_ff, dq_quo;
   logic [PT_W-1:0]          l1_den_ff;
   logic signed [SLOPE_W-1:0] k_in, k_ff;
   logic signed [SLOPE_W-1:0] slope_pr_ff;
   line_side_type            k_side_ff, pr_side_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_in, sh_in;
   logic signed [ICPT_W-1:0] icpt_in;
   rsp_type                  out_ff;

   always_comb begin
      dx     = DIFF_W'(ex) - DIFF_W'(sx);
      dy     = DIFF_W'(ey) - DIFF_W'(sy);
      msum_x = (DIFF_W'(sx) + DIFF_W'(ex) + DIFF_W'(1)) >>> 1;
      msum_y = (DIFF_W'(sy) + DIFF_W'(ey) + DIFF_W'(1)) >>> 1;
      adx    = dx[DIFF_W-1] ? -dx : dx;
      ady    = dy[DIFF_W-1] ? -dy : dy;
      l1_side_in.side = in_side;
      l1_side_in.sx   = sx;
      l1_side_in.sy   = sy;
      l1_side_in.mx   = msum_x[PT_W-1:0];
      l1_side_in.my   = msum_y[PT_W-1:0];
      l1_side_in.vert = (dx == '0);
      l1_side_in.neg  = dx[DIFF_W-1] ^ dy[DIFF_W-1];
   end

   qeel_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (l1_v_ff),
      .in_num    (l1_num_ff),
      .in_den    (l1_den_ff),
      .in_side   (l1_side_ff),
      .out_valid (dq_v),
      .out_quo   (dq_quo),
      .out_side  (dq_side)
   );

   always_comb begin
      if (dq_side.vert) begin
         k_in = SLOPE_VERT;
      end else if (dq_side.neg) begin
         k_in = (dq_quo > QUO_NEG_LIM) ? SLOPE_MIN : SLOPE_W'(-dq_quo);
      end else begin
         k_in = (dq_quo > QUO_POS_LIM) ? SLOPE_MAX : SLOPE_W'(dq_quo);
      end
   end

   always_comb begin
      acc_in = (ACC_W'(pr_side_ff.sy) <<< FRAC_W) - ACC_W'(prod_ff) + ICPT_RND;
      sh_in  = acc_in >>> ICPT_SH;
      if (sh_in > ICPT_HI) begin
         icpt_in = ICPT_HI[ICPT_W-1:0];
      end else if (sh_in < ICPT_LO) begin
         icpt_in = ICPT_LO[ICPT_W-1:0];
      end else begin
         icpt_in = sh_in[ICPT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_v_ff  <= 1'b0;
         k_v_ff   <= 1'b0;
         pr_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         l1_v_ff  <= in_valid;
         k_v_ff   <= dq_v;
         pr_v_ff  <= k_v_ff;
         out_v_ff <= pr_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l1_side_ff   <= l1_side_in;
         l1_num_ff    <= {ady[PT_W-1:0], {FRAC_W{1'b0}}};
         l1_den_ff    <= adx[PT_W-1:0];
         k_ff         <= k_in;
         k_side_ff    <= dq_side;
         prod_ff      <= k_ff * k_side_ff.sx;
         pr_side_ff   <= k_side_ff;
         out_ff.side  <= pr_side_ff.side;
         out_ff.sx    <= pr_side_ff.sx;
         out_ff.sy    <= pr_side_ff.sy;
         out_ff.mx    <= pr_side_ff.mx;
         out_ff.my    <= pr_side_ff.my;
         out_ff.slope <= slope_pr_ff;
         out_ff.icpt  <= icpt_in;
      end
   end

   // slope rides beside the product stage
   always_ff @(posedge clock) begin
      if (adv) begin
         slope_pr_ff <= k_ff;
      end
   end

   assign out_valid = out_v_ff;
   assign out_rsp   = out_ff;

endmodule

>>> rtl/quad_edge_expand_and_line_fit_unit.sv
// Quad edge expand and line fit: top level with register file, edge sequencer and pipelines.
//
// Usage: one req beat carries an object index, four corners and the center (Q12.4).
// The block pushes each corner outward by near_ratio and far_ratio and returns four
// rsp beats, edges 0 to 3 in order, tlast on edge 3. An index above max_valid_index
// is taken and dropped with no rsp beats.
// Throughput: one rsp beat per cycle while rsp_tready is high, four rsp beats per req
// beat; req_tready stays high through the last edge of the item in flight, so items
// follow each other with no gap. The edge sequencer sets that rate.
// Path: the first rsp beat of an item passes through the sequencer register, the
// corner push-out, the edge deltas register, the slope divider (one quotient bit
// per stage), then clamp, intercept product and output register.
// Stall: while rsp_tready is low with rsp_tvalid high the whole pipeline holds;
// nothing is lost or repeated. The user writes configuration through csr_ only
// while idle; the block itself does not enforce this. Reset: synchronous, active
// high; clears the pipeline and restores the ratio and index limit registers to their defaults.
module quad_edge_expand_and_line_fit_unit import qeel_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // object_index, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y,
   // corner4_x, corner4_y, mid_x_in, mid_y_in, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // card_index, edge_res, start_x, start_y, midpoint_x, midpoint_y, slope,
   // intercept, ctr_x, ctr_y
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [RATIO_W-1:0]    csr_wr_data
);

   logic [RATIO_W-1:0] near_ff, far_ff;
   logic [IDX_W-1:0]   max_idx_ff;

   logic                      busy_ff;
   logic [EDGE_W-1:0]         cnt_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic signed [COORD_W-1:0] mx_ff, my_ff;
   logic signed [COORD_W-1:0] rx_ff [4];
   logic signed [COORD_W-1:0] ry_ff [4];
   logic signed [COORD_W-1:0] req_cx [4];
   logic signed [COORD_W-1:0] req_cy [4];
   logic [IDX_W-1:0]          req_idx;

   logic     adv, req_acc, emit, load, even;
   side_type side_s0;
   logic     ev_ff [3];
   side_type es_ff [3];
   logic signed [COORD_W-1:0] ni_x, fi_x, nj_x, fj_x, ni_y, fi_y, nj_y, fj_y;
   logic signed [PT_W-1:0]    exi, eyi, exj, eyj;
   rsp_type                   rsp;

   assign req_idx = req_tdata[IDX_W-1:0];
   genvar c;
   generate
      for (c = 0; c < 4; c++) begin : g_unpack
         assign req_cx[c] = req_tdata[IDX_W + 2*c*COORD_W +: COORD_W];
         assign req_cy[c] = req_tdata[IDX_W + (2*c+1)*COORD_W +: COORD_W];
      end
   endgenerate

   assign adv        = !rsp_tvalid || rsp_tready;
   assign emit       = busy_ff && adv;
   assign req_tready = !busy_ff || (adv && cnt_ff == EDGE_LAST);
   assign req_acc    = req_tvalid && req_tready;
   assign load       = req_acc && (req_idx <= max_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff    <= NEAR_RATIO_RST;
         far_ff     <= FAR_RATIO_RST;
         max_idx_ff <= MAX_INDEX_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NEAR_RATIO: near_ff    <= csr_wr_data;
            CSR_FAR_RATIO:  far_ff     <= csr_wr_data;
            CSR_MAX_INDEX:  max_idx_ff <= csr_wr_data[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= EDGE_FIRST;
      end else if (load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= EDGE_FIRST;
      end else if (emit) begin
         busy_ff <= (cnt_ff != EDGE_LAST);
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   // rotate so slot 0 always holds the start corner of the current edge
   always_ff @(posedge clock) begin
      if (load) begin
         idx_ff <= req_idx;
         mx_ff  <= req_tdata[IDX_W + 8*COORD_W +: COORD_W];
         my_ff  <= req_tdata[IDX_W + 9*COORD_W +: COORD_W];
         for (int k = 0; k < 4; k++) begin
            rx_ff[k] <= req_cx[k];
            ry_ff[k] <= req_cy[k];
         end
      end else if (emit) begin
         for (int k = 0; k < 4; k++) begin
            rx_ff[k] <= rx_ff[(k+1)%4];
            ry_ff[k] <= ry_ff[(k+1)%4];
         end
      end
   end

   assign even = !cnt_ff[0];
   assign ni_x = even ? rx_ff[1] : rx_ff[3];
   assign fi_x = even ? rx_ff[3] : rx_ff[1];
   assign nj_x = even ? rx_ff[0] : rx_ff[2];
   assign fj_x = even ? rx_ff[2] : rx_ff[0];
   assign ni_y = even ? ry_ff[1] : ry_ff[3];
   assign fi_y = even ? ry_ff[3] : ry_ff[1];
   assign nj_y = even ? ry_ff[0] : ry_ff[2];
   assign fj_y = even ? ry_ff[2] : ry_ff[0];

   qeel_expand u_exp_xi (.clock(clock), .adv(adv), .p(rx_ff[0]), .qn(ni_x), .qf(fi_x),
      .near_ratio(near_ff), .far_ratio(far_ff), .e(exi));
   qeel_expand u_exp_yi (.clock(clock), .adv(adv), .p(ry_ff[0]), .qn(ni_y), .qf(fi_y),
      .near_ratio(near_ff), .far_ratio(far_ff), .e(eyi));
   qeel_expand u_exp_xj (.clock(clock), .adv(adv), .p(rx_ff[1]), .qn(nj_x), .qf(fj_x),
      .near_ratio(near_ff), .far_ratio(far_ff), .e(exj));
   qeel_expand u_exp_yj (.clock(clock), .adv(adv), .p(ry_ff[1]), .qn(nj_y), .qf(fj_y),
      .near_ratio(near_ff), .far_ratio(far_ff), .e(eyj));

   always_comb begin
      side_s0.idx     = idx_ff;
      side_s0.edge_no = cnt_ff;
      side_s0.last    = (cnt_ff == EDGE_LAST);
      side_s0.cx      = mx_ff;
      side_s0.cy      = my_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            ev_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         ev_ff[0] <= busy_ff;
         ev_ff[1] <= ev_ff[0];
         ev_ff[2] <= ev_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         es_ff[0] <= side_s0;
         es_ff[1] <= es_ff[0];
         es_ff[2] <= es_ff[1];
      end
   end

   qeel_line u_line (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (ev_ff[2]),
      .in_side   (es_ff[2]),
      .sx        (exi),
      .sy        (eyi),
      .ex        (exj),
      .ey        (eyj),
      .out_valid (rsp_tvalid),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = {rsp.side.cy, rsp.side.cx, rsp.icpt, rsp.slope, rsp.my, rsp.mx,
                       rsp.sy, rsp.sx, rsp.side.edge_no, rsp.side.idx};
   assign rsp_tlast = rsp.side.last;

`ifndef SYNTHESIS
   a_last_on_edge3: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp.side.edge_no == EDGE_LAST)))
      else $error("tlast does not match edge 3");

   a_edge_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && rsp.side.edge_no == $past(rsp.side.edge_no) + 2'd1))
      else $error("edge beats out of order or gapped");

   a_ready_busy: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && req_tready) |-> (cnt_ff == EDGE_LAST && adv))
      else $error("new item taken while edges pending");
`endif

endmodule

>>> verif/tb_quad_edge_expand_and_line_fit_unit.sv
// Self-checking testbench for the quad edge expand and line fit unit.
module tb_quad_edge_expand_and_line_fit_unit;
   import qeel_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [IDX_W-1:0]          idx;
      logic signed [COORD_W-1:0] px[4];
      logic signed [COORD_W-1:0] py[4];
      logic signed [COORD_W-1:0] ctr_x;
      logic signed [COORD_W-1:0] ctr_y;
      bit                        known;
      longint                    known_slope;
      longint                    known_icpt;
   } quad_type;

   typedef struct {
      logic [IDX_W-1:0]          idx;
      logic [EDGE_W-1:0]         edge_no;
      logic signed [PT_W-1:0]    sx, sy, mx, my;
      logic signed [SLOPE_W-1:0] slope;
      logic signed [ICPT_W-1:0]  icpt;
      logic signed [COORD_W-1:0] cx, cy;
      logic                      last;
   } edge_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [RATIO_W-1:0]    csr_wr_data = '0;

   logic [RATIO_W-1:0] near_q = NEAR_RATIO_RST;
   logic [RATIO_W-1:0] far_q  = FAR_RATIO_RST;
   logic [IDX_W-1:0]   limit_q = MAX_INDEX_RST;

   edge_type expected_edges[$];
   int       err_count = 0;
   bit       rx_running = 1'b0;
   quad_type dir_rows[$];

   quad_edge_expand_and_line_fit_unit u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic longint clamp(longint v, int w);
      longint hi, lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : (v < lo) ? lo : v;
   endfunction

   function automatic longint push_out(longint p, longint qn, longint qf);
      longint acc;
      acc = p * 65536 + longint'(near_q) * (p - qn) + longint'(far_q) * (p - qf);
      return clamp((acc + 32768) >>> 16, PT_W);
   endfunction

   task automatic predict_edges(quad_type q);
      longint   ex[4], ey[4];
      longint   sx, sy, dx, dy, k, b, ak, ax;
      int       nn[4] = '{1, 0, 3, 2};
      int       fn[4] = '{3, 2, 1, 0};
      int       j;
      edge_type e;
      if (q.idx > limit_q) return;
      for (int i = 0; i < 4; i++) begin
         ex[i] = push_out(q.px[i], q.px[nn[i]], q.px[fn[i]]);
         ey[i] = push_out(q.py[i], q.py[nn[i]], q.py[fn[i]]);
      end
      for (int i = 0; i < 4; i++) begin
         j = (i + 1) % 4;
         sx = ex[i];
         sy = ey[i];
         dx = ex[j] - sx;
         dy = ey[j] - sy;
         if (dx == 0) k = SLOPE_VERT;
         else k = clamp((dy * 65536) / dx, SLOPE_W);
         ak = (k < 0) ? -k : k;
         ax = (sx < 0) ? -sx : sx;
         if (ak != 0 && ax > (64'sd1 <<< 61) / ak)
            b = ((k < 0) != (sx < 0)) ? clamp(64'h7fff_ffff_ffff_ffff, ICPT_W)
                                      : clamp(64'h8000_0000_0000_0000, ICPT_W);
         else
            b = clamp((sy * 65536 - k * sx + 8) >>> 4, ICPT_W);
         if (q.known) begin
            k = q.known_slope;
            b = q.known_icpt;
         end
         e.idx     = q.idx;
         e.edge_no = EDGE_W'(i);
         e.sx      = PT_W'(sx);
         e.sy      = PT_W'(sy);
         e.mx      = PT_W'((sx + ex[j] + 1) >>> 1);
         e.my      = PT_W'((sy + ey[j] + 1) >>> 1);
         e.slope   = SLOPE_W'(k);
         e.icpt    = ICPT_W'(b);
         e.cx      = q.ctr_x;
         e.cy      = q.ctr_y;
         e.last    = (EDGE_W'(i) == EDGE_LAST);
         expected_edges.push_back(e);
      end
   endtask

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         err_count++;
      end
   endtask

   function automatic quad_type mk(int idx, int x1, int y1, int x2, int y2, int x3, int y3,
                                   int x4, int y4, int cx, int cy);
      quad_type q;
      q.idx = IDX_W'(idx);
      q.px = '{COORD_W'(x1), COORD_W'(x2), COORD_W'(x3), COORD_W'(x4)};
      q.py = '{COORD_W'(y1), COORD_W'(y2), COORD_W'(y3), COORD_W'(y4)};
      q.ctr_x = COORD_W'(cx);
      q.ctr_y = COORD_W'(cy);
      q.known = 1'b0;
      q.known_slope = 0;
      q.known_icpt = 0;
      return q;
   endfunction

   function automatic quad_type rand_quad();
      quad_type q;
      int       cx, cy, r;
      q = mk($urandom_range(0, 63), 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      if ($urandom_range(0, 3) == 0) begin
         for (int i = 0; i < 4; i++) begin
            q.px[i] = COORD_W'($urandom);
            q.py[i] = COORD_W'($urandom);
         end
         q.ctr_x = COORD_W'($urandom);
         q.ctr_y = COORD_W'($urandom);
      end else begin
         cx = $urandom_range(0, 40000) - 20000;
         cy = $urandom_range(0, 40000) - 20000;
         r  = $urandom_range(1, 4000);
         q.ctr_x = COORD_W'(cx);
         q.ctr_y = COORD_W'(cy);
         q.px = '{COORD_W'(cx - r - $urandom_range(0, 300)),
                  COORD_W'(cx + r + $urandom_range(0, 300)),
                  COORD_W'(cx + r + $urandom_range(0, 300)),
                  COORD_W'(cx - r - $urandom_range(0, 300))};
         q.py = '{COORD_W'(cy - r - $urandom_range(0, 300)),
                  COORD_W'(cy - r - $urandom_range(0, 300)),
                  COORD_W'(cy + r + $urandom_range(0, 300)),
                  COORD_W'(cy + r + $urandom_range(0, 300))};
      end
      return q;
   endfunction

   int tx_fast = 0;
   int rx_fast = 0;

   task automatic send_quad(quad_type q);
      int gap;
      if (tx_fast == 0 && $urandom_range(0, 9) == 0) tx_fast = $urandom_range(5, 20);
      gap = (tx_fast > 0) ? 0 : $urandom_range(0, 15);
      if (tx_fast > 0) tx_fast--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, q.ctr_y, q.ctr_x, q.py[3], q.px[3], q.py[2], q.px[2],
                     q.py[1], q.px[1], q.py[0], q.px[0], q.idx};
      do @(posedge clock); while (!req_tready);
      predict_edges(q);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (expected_edges.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [RATIO_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_NEAR_RATIO: near_q  = val;
         CSR_FAR_RATIO:  far_q   = val;
         CSR_MAX_INDEX:  limit_q = val[IDX_W-1:0];
         default: ;
      endcase
   endtask

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            wait (expected_edges.size() == 0);
         end
         send_quad(rand_quad());
      end
   endtask

   always begin
      int       stall;
      edge_type e;
      wait (rx_running);
      if (rx_fast == 0 && $urandom_range(0, 9) == 0) rx_fast = $urandom_range(5, 30);
      stall = (rx_fast > 0) ? 0 : $urandom_range(0, 15);
      if (rx_fast > 0) rx_fast--;
      if (stall > 0) begin
         rsp_tready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
      rsp_tready <= 1'b1;
      do @(posedge clock); while (!rsp_tvalid);
      if (expected_edges.size() == 0) begin
         $error("unexpected result beat");
         err_count++;
      end else begin
         e = expected_edges.pop_front();
         check_field("card_index", e.idx, rsp_tdata[5:0]);
         check_field("edge_res", e.edge_no, rsp_tdata[7:6]);
         check_field("start_x", e.sx, $signed(rsp_tdata[25:8]));
         check_field("start_y", e.sy, $signed(rsp_tdata[43:26]));
         check_field("midpoint_x", e.mx, $signed(rsp_tdata[61:44]));
         check_field("midpoint_y", e.my, $signed(rsp_tdata[79:62]));
         check_field("slope", e.slope, $signed(rsp_tdata[111:80]));
         check_field("intercept", e.icpt, $signed(rsp_tdata[159:112]));
         check_field("ctr_x", e.cx, $signed(rsp_tdata[175:160]));
         check_field("ctr_y", e.cy, $signed(rsp_tdata[191:176]));
         check_field("last", e.last, rsp_tlast);
      end
   end

   initial begin
      quad_type q;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      rx_running = 1'b1;

      q = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      q.known = 1'b1;
      q.known_slope = 65536000;
      q.known_icpt = 0;
      dir_rows.push_back(q);
      dir_rows.push_back(mk(54, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 32767));
      dir_rows.push_back(mk(1, -32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768, -32768));
      dir_rows.push_back(mk(2, -32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                            0, 0));
      dir_rows.push_back(mk(3, 32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768,
                            -1, -1));
      dir_rows.push_back(mk(4, -160, -160, 160, -160, 160, 160, -160, 160, 0, 0));
      dir_rows.push_back(mk(5, 0, -30000, 1, 30000, 2, -30000, 3, 30000, 5, 5));
      dir_rows.push_back(mk(6, 0, 30000, 1, -30000, 0, 30000, 1, -30000, 5, 5));
      dir_rows.push_back(mk(63, 100, 100, 200, 100, 200, 200, 100, 200, 7, 7));
      dir_rows.push_back(mk(55, 100, 100, 200, 100, 200, 200, 100, 200, 7, 7));
      dir_rows.push_back(mk(42, 1, 2, 3, 4, 5, 6, 7, 8, -32768, 32767));
      dir_rows.push_back(mk(7, 20000, -20000, -20000, 20000, 20000, 20000, -20000,
                            -20000, 123, -123));
      foreach (dir_rows[i]) send_quad(dir_rows[i]);
      run_random(40);
      drain();

      write_csr(CSR_NEAR_RATIO, '0);
      write_csr(CSR_FAR_RATIO, '0);
      write_csr(CSR_MAX_INDEX, 16'd63);
      write_csr(CSR_UNUSED, 16'hffff);
      send_quad(mk(63, -32768, 32767, 32767, 32767, 32767, -32768, -32768, -32768, 0, 0));
      run_random(35);
      drain();

      write_csr(CSR_NEAR_RATIO, 16'hffff);
      write_csr(CSR_FAR_RATIO, 16'hffff);
      write_csr(CSR_MAX_INDEX, 16'hffc0);
      send_quad(mk(0, -32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767, 1, 1));
      run_random(35);
      drain();

      write_csr(CSR_NEAR_RATIO, RATIO_W'($urandom));
      write_csr(CSR_FAR_RATIO, RATIO_W'($urandom));
      write_csr(CSR_MAX_INDEX, RATIO_W'($urandom_range(30, 63)));
      run_random(40);
      drain();

      if (err_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
